/* rtl/timestamp_watermark_reorder_buffer_top_assert.svh */
// ----------------------------------------------------------------------------
// timestamp_watermark_reorder_buffer_top assertion macros
// Shared forms for the concurrent checks of the reorder buffer top level.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_WATERMARK_REORDER_BUFFER_TOP_ASSERT_SVH
`define TIMESTAMP_WATERMARK_REORDER_BUFFER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define TWRB_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TWRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/twrb_pkg.sv */
// ----------------------------------------------------------------------------
// twrb_pkg
// Types, widths and constants shared by the watermark reorder buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twrb_pkg;

	localparam int PENDING_DEPTH = 32;
	localparam int RESULT_LIMIT  = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
	localparam int REL_W   = $clog2(RESULT_LIMIT + 1);
	localparam int STAMP_W = 62;
	localparam int ARR_W   = 63;
	localparam int TAG_W   = 16;
	localparam int LVL_W   = 3;
	localparam int WMS_W   = 16;
	localparam int CAP_W   = 6;
	// 65535 ms in ns needs 36 bits
	localparam int WIN_W   = 46;
	localparam int CMP_W   = 8;
	localparam int PADDR_W = 4;
	localparam int DATA_W  = 32;

	localparam logic [STAMP_W-1:0] NS_PER_SECOND = 62'd1000000000;
	localparam logic [WIN_W-1:0]   NS_PER_MS     = 46'd1000000;
	localparam logic [CAP_W-1:0]   CAP_RESET     = 6'd32;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	localparam logic [1:0] REG_LEVEL_FLOOR = 2'd0;
	localparam logic [1:0] REG_WINDOW      = 2'd1;
	localparam logic [1:0] REG_CAPACITY    = 2'd2;

	typedef struct packed {
		logic               kind;
		logic [LVL_W-1:0]   level;
		logic [31:0]        stamp_seconds;
		logic [29:0]        stamp_nanos;
		logic [ARR_W-1:0]   arrival_ns;
		logic [TAG_W-1:0]   record_tag;
	} in_t;

	typedef struct packed {
		logic [STAMP_W-1:0] out_stamp_ns;
		logic [ARR_W-1:0]   out_arrival_ns;
		logic [TAG_W-1:0]   out_tag;
		logic               last_of_run;
	} out_t;

	typedef struct packed {
		logic               flush;
		logic [STAMP_W-1:0] stamp;
		logic [ARR_W-1:0]   arrival;
		logic [TAG_W-1:0]   tag;
	} cmd_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [ARR_W-1:0]   arrival;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	typedef struct packed {
		logic [WIN_W-1:0]   win_ns;
		logic [CAP_W-1:0]   capacity_limit;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
	} stat_t;

endpackage

/* rtl/twrb_front.sv */
// ----------------------------------------------------------------------------
// twrb_front
// Input stage: takes items, discards low-level records, forms the timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twrb_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [twrb_pkg::LVL_W-1:0] level_floor,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  twrb_pkg::in_t              in_data,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output twrb_pkg::cmd_t             cmd
);

	twrb_pkg::in_t                  item_s1;
	logic                           valid_s1;
	logic                           keep;
	logic                           advance;
	logic [twrb_pkg::STAMP_W-1:0]   stamp;

	// flushes always pass, records only at or above the level floor
	assign keep = (item_s1.kind == twrb_pkg::KIND_FLUSH) || (item_s1.level >= level_floor);
	assign advance = valid_s1 & (~keep | cmd_ready);
	assign in_ready = ~valid_s1 | advance;
	assign cmd_valid = valid_s1 & keep;

	assign stamp = twrb_pkg::STAMP_W'(item_s1.stamp_seconds) * twrb_pkg::NS_PER_SECOND
		+ twrb_pkg::STAMP_W'(item_s1.stamp_nanos);

	assign cmd.flush   = (item_s1.kind == twrb_pkg::KIND_FLUSH);
	assign cmd.stamp   = stamp;
	assign cmd.arrival = item_s1.arrival_ns;
	assign cmd.tag     = item_s1.record_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

/* rtl/twrb_queue.sv */
// ----------------------------------------------------------------------------
// twrb_queue
// Short command queue between the input stage and the sorted store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twrb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  twrb_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output twrb_pkg::cmd_t pop_cmd
);

	localparam int PTR_W  = $clog2(twrb_pkg::QUEUE_DEPTH);
	localparam int FILL_W = $clog2(twrb_pkg::QUEUE_DEPTH + 1);

	twrb_pkg::cmd_t     slots_q [twrb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [FILL_W-1:0]  fill_q;
	logic               push;
	logic               pop;

	assign push_ready = (fill_q != FILL_W'(twrb_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slots_q[rd_q];
	assign push = push_valid & push_ready;
	assign pop  = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(twrb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(twrb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/twrb_back.sv */
// ----------------------------------------------------------------------------
// twrb_back
// Sorted store of pending records: inserts by shifting cells in parallel, releases from the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twrb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  twrb_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  twrb_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output twrb_pkg::out_t out_data,
	output twrb_pkg::stat_t sts
);

	localparam int MARK_W = twrb_pkg::STAMP_W + 1;
	localparam int RELX_W = twrb_pkg::REL_W + 1;
	localparam int DEPTH  = twrb_pkg::PENDING_DEPTH;

	typedef enum logic {
		ST_IDLE,
		ST_RELEASE
	} state_t;

	state_t                          state_q;
	twrb_pkg::entry_t                cells_q [DEPTH];
	twrb_pkg::entry_t                cells_d [DEPTH];
	logic [twrb_pkg::CNT_W-1:0]      count_q;
	logic [twrb_pkg::STAMP_W-1:0]    max_q;
	logic                            seen_q;
	logic                            all_q;
	logic [twrb_pkg::REL_W-1:0]      rel_q;
	twrb_pkg::out_t                  out_q;
	logic                            out_valid_q;

	twrb_pkg::entry_t                new_entry;
	logic [DEPTH-1:0]                lt_eff;
	logic [twrb_pkg::CMP_W-1:0]      cap_eff;
	logic                            full;
	logic                            take;
	logic                            ins;
	logic [MARK_W-1:0]               mark0;
	logic [MARK_W-1:0]               mark1;
	logic                            elig0;
	logic                            elig1;
	logic                            out_free;
	logic                            pop;

	assign new_entry.stamp   = cmd.stamp;
	assign new_entry.arrival = cmd.arrival;
	assign new_entry.tag     = cmd.tag;

	assign cap_eff = (twrb_pkg::CMP_W'(cfg.capacity_limit) > twrb_pkg::CMP_W'(DEPTH))
		? twrb_pkg::CMP_W'(DEPTH) : twrb_pkg::CMP_W'(cfg.capacity_limit);
	assign full = (twrb_pkg::CMP_W'(count_q) >= cap_eff);

	assign cmd_ready = (state_q == ST_IDLE);
	assign take = cmd_ready & cmd_valid;
	assign ins  = take & ~cmd.flush & ~full;

	// head and next entry against the watermark; the store is sorted so the
	// run ends at the first entry that fails
	assign mark0 = MARK_W'(cells_q[0].stamp) + MARK_W'(cfg.win_ns);
	assign mark1 = MARK_W'(cells_q[1].stamp) + MARK_W'(cfg.win_ns);
	assign elig0 = (count_q != '0) && (rel_q < twrb_pkg::REL_W'(twrb_pkg::RESULT_LIMIT))
		&& (all_q || (mark0 <= MARK_W'(max_q)));
	assign elig1 = (count_q > twrb_pkg::CNT_W'(1))
		&& ((RELX_W'(rel_q) + RELX_W'(1)) < RELX_W'(twrb_pkg::RESULT_LIMIT))
		&& (all_q || (mark1 <= MARK_W'(max_q)));

	assign out_free = ~out_valid_q | out_ready;
	assign pop = (state_q == ST_RELEASE) & elig0 & out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign sts.count = count_q;

	// each cell: keep, take the new record, or take its neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign lt_eff[g] = (twrb_pkg::CNT_W'(g) >= count_q)
			|| (cmd.stamp < cells_q[g].stamp)
			|| ((cmd.stamp == cells_q[g].stamp) && (cmd.arrival < cells_q[g].arrival));
		if (g == 0) begin : g_head
			assign cells_d[g] = ins ? (lt_eff[g] ? new_entry : cells_q[g])
				: (pop ? cells_q[g+1] : cells_q[g]);
		end else if (g == DEPTH - 1) begin : g_tail
			assign cells_d[g] = ins
				? (lt_eff[g] ? (lt_eff[g-1] ? cells_q[g-1] : new_entry) : cells_q[g])
				: cells_q[g];
		end else begin : g_mid
			assign cells_d[g] = ins
				? (lt_eff[g] ? (lt_eff[g-1] ? cells_q[g-1] : new_entry) : cells_q[g])
				: (pop ? cells_q[g+1] : cells_q[g]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			cells_q[i] <= cells_d[i];
		end
		if (pop) begin
			out_q.out_stamp_ns   <= cells_q[0].stamp;
			out_q.out_arrival_ns <= cells_q[0].arrival;
			out_q.out_tag        <= cells_q[0].tag;
			out_q.last_of_run    <= ~elig1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			max_q       <= '0;
			seen_q      <= 1'b0;
			all_q       <= 1'b0;
			rel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (cmd.flush) begin
							all_q   <= 1'b1;
							rel_q   <= '0;
							state_q <= ST_RELEASE;
						end else if (!full) begin
							count_q <= count_q + 1'b1;
							if (!seen_q || (cmd.stamp > max_q)) begin
								max_q <= cmd.stamp;
							end
							seen_q  <= 1'b1;
							all_q   <= 1'b0;
							rel_q   <= '0;
							state_q <= ST_RELEASE;
						end
					end
				end
				ST_RELEASE: begin
					if (!elig0) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						count_q <= count_q - 1'b1;
						rel_q   <= rel_q + 1'b1;
						if (!elig1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/timestamp_watermark_reorder_buffer_top.sv */
// ----------------------------------------------------------------------------
// timestamp_watermark_reorder_buffer_top
// Watermark reorder buffer for timestamped records, with APB register port.
// ----------------------------------------------------------------------------
// An item is registered in the input stage, where records below the level
// floor end, and then waits in a two-beat command queue. In the back end a
// record is placed in the sorted store and the eligible records are then
// released in turn; a flush releases the same way, and a record that finds
// the store full is dropped. A stalled output holds the release. The sorted
// store releases only through its head, one beat per cycle while the output
// is free, and that sets the rate. The input side keeps taking items while
// the store works, until the command queue is full. A register write to the
// window reaches the reorder window through window_ms_q and then win_ns_q.
`timescale 1ns / 1ps
`include "timestamp_watermark_reorder_buffer_top_assert.svh"

module timestamp_watermark_reorder_buffer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [twrb_pkg::PADDR_W-1:0] paddr,
	input  logic [twrb_pkg::DATA_W-1:0]  pwdata,
	output logic [twrb_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  twrb_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output twrb_pkg::out_t               out_data
);

	localparam logic [twrb_pkg::CNT_W-1:0] DEPTH_CNT = twrb_pkg::CNT_W'(twrb_pkg::PENDING_DEPTH);

	logic [twrb_pkg::LVL_W-1:0]  level_floor_q;
	logic [twrb_pkg::WMS_W-1:0]  window_ms_q;
	logic [twrb_pkg::CAP_W-1:0]  capacity_q;
	logic [twrb_pkg::WIN_W-1:0]  win_ns_q;
	logic                        wr_en;
	logic [1:0]                  reg_idx;

	logic                        fq_valid;
	logic                        fq_ready;
	twrb_pkg::cmd_t              fq_cmd;
	logic                        qb_valid;
	logic                        qb_ready;
	twrb_pkg::cmd_t              qb_cmd;
	twrb_pkg::cfg_t              back_cfg;
	twrb_pkg::stat_t             sts;

	logic [twrb_pkg::CNT_W-1:0]  count_prev_q;
	logic                        count_hold;
	logic                        count_inc;
	logic                        count_dec;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_floor_q <= '0;
			window_ms_q   <= '0;
			capacity_q    <= twrb_pkg::CAP_RESET;
			win_ns_q      <= '0;
		end else begin
			win_ns_q <= twrb_pkg::WIN_W'(window_ms_q) * twrb_pkg::NS_PER_MS;
			if (wr_en) begin
				unique case (reg_idx)
					twrb_pkg::REG_LEVEL_FLOOR: level_floor_q <= pwdata[twrb_pkg::LVL_W-1:0];
					twrb_pkg::REG_WINDOW:      window_ms_q   <= pwdata[twrb_pkg::WMS_W-1:0];
					twrb_pkg::REG_CAPACITY:    capacity_q    <= pwdata[twrb_pkg::CAP_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			twrb_pkg::REG_LEVEL_FLOOR: prdata = twrb_pkg::DATA_W'(level_floor_q);
			twrb_pkg::REG_WINDOW:      prdata = twrb_pkg::DATA_W'(window_ms_q);
			twrb_pkg::REG_CAPACITY:    prdata = twrb_pkg::DATA_W'(capacity_q);
			default:                   prdata = '0;
		endcase
	end

	assign back_cfg.win_ns         = win_ns_q;
	assign back_cfg.capacity_limit = capacity_q;

	twrb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.level_floor (level_floor_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.cmd_valid   (fq_valid),
		.cmd_ready   (fq_ready),
		.cmd         (fq_cmd)
	);

	twrb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	twrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.sts       (sts)
	);

	// pending count from the previous edge, for the step checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_prev_q <= '0;
		end else begin
			count_prev_q <= sts.count;
		end
	end

	assign count_hold = (sts.count == count_prev_q);
	assign count_inc  = (sts.count == count_prev_q + 1'b1);
	assign count_dec  = (sts.count + 1'b1 == count_prev_q);

	`TWRB_ASSERT_ALWAYS(a_count_bound, sts.count <= DEPTH_CNT, "pending count above store depth")
	`TWRB_ASSERT_ALWAYS(a_count_step, count_hold || count_inc || count_dec, "pending count jumped")
	`TWRB_ASSERT_ALWAYS(a_pop_beat, !count_dec || out_valid, "record left without an output beat")

endmodule
